>>> rtl/core/armr_pkg.sv
// ----------------------------------------------------------------------------
// armr_pkg
// Shared types and constants of the address region message router: request
// and response payloads, the query that walks the region cells, the table
// write bus, result codes and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package armr_pkg;

    // default parameter values
    localparam int REGIONS_DEF   = 16;
    localparam int DEVICES_DEF   = 16;
    localparam int ADDR_BITS_DEF = 32;

    // fixed field widths
    localparam int ID_W   = 4;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;

    // device count after reset
    localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ROUTE = 1'b1;

    // read response marker
    localparam logic READ_RSP_MARK = 1'b1;

    // route kind codes
    localparam logic [1:0] KIND_BY_SRC  = 2'd0;
    localparam logic [1:0] KIND_BY_DST  = 2'd1;
    localparam logic [1:0] KIND_BY_ADDR = 2'd2;
    localparam logic [1:0] KIND_LOAD    = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISS    = 2'd1;
    localparam logic [1:0] STAT_OVERLAP = 2'd2;
    localparam logic [1:0] STAT_BAD_ID  = 2'd3;

    // request payload
    typedef struct packed {
        logic              cmd;
        logic [3:0]        slot_index;
        logic [DATA_W-1:0] region_start;
        logic [DATA_W-1:0] region_length;
        logic [ID_W-1:0]   region_device;
        logic              region_enabled;
        logic              msg_is_read_response;
        logic              msg_has_dst;
        logic [ID_W-1:0]   msg_src_id;
        logic [ID_W-1:0]   msg_dst_id;
        logic [DATA_W-1:0] msg_address;
    } req_t;

    // response payload
    typedef struct packed {
        logic [ID_W-1:0] dest_device;
        logic [1:0]      route_kind;
        logic [1:0]      status;
    } rsp_t;

    // query handed from cell to cell
    typedef struct packed {
        logic            hit;
        logic [ID_W-1:0] hit_owner;
        logic            overlap;
        req_t            req;
    } query_t;

    // table write broadcast to all cells
    typedef struct packed {
        logic              en;
        logic              set;
        logic [3:0]        slot;
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] length;
        logic [ID_W-1:0]   owner;
    } tbl_wr_t;

    // controller states
    typedef enum logic {
        CTL_IDLE,
        CTL_SWEEP
    } ctl_state_t;

endpackage

`default_nettype wire

>>> rtl/core/armr_cell.sv
// ----------------------------------------------------------------------------
// armr_cell
// One region table entry. Checks the passing query against its entry
// (overlap for a load, address match for a route) and registers the query
// for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module armr_cell #(
    parameter int ADDR_BITS = armr_pkg::ADDR_BITS_DEF,
    parameter int INDEX     = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             vld_in,
    input  wire armr_pkg::query_t q_in,
    input  wire armr_pkg::tbl_wr_t wr,
    output logic                  vld_out,
    output armr_pkg::query_t      q_out
);
    import armr_pkg::*;

    localparam int SPAN_W = ((ADDR_BITS > DATA_W) ? ADDR_BITS : DATA_W) + 1;

    // entry storage
    logic [ADDR_BITS-1:0] start_reg;
    logic [SPAN_W-1:0]    end_reg;
    logic [ID_W-1:0]      owner_reg;
    logic                 nonempty_reg;
    logic                 valid_reg;

    // query stage toward the next cell
    logic   vld_reg;
    query_t q_reg;
    query_t q_next;

    logic [ADDR_BITS-1:0] q_start;
    logic [SPAN_W-1:0]    q_end;
    logic [ADDR_BITS-1:0] q_addr;
    logic                 own_slot;
    logic [ADDR_BITS-1:0] w_start;
    logic                 wr_hit;

    // addresses wrap at the address width, region ends do not
    assign q_start  = ADDR_BITS'(SPAN_W'(q_in.req.region_start));
    assign q_end    = SPAN_W'(q_start) + SPAN_W'(q_in.req.region_length);
    assign q_addr   = ADDR_BITS'(SPAN_W'(q_in.req.msg_address));
    assign own_slot = (32'(q_in.req.slot_index) == 32'(INDEX));
    assign w_start  = ADDR_BITS'(SPAN_W'(wr.start));
    assign wr_hit   = wr.en && (32'(wr.slot) == 32'(INDEX));

    // compare the query against this entry
    always_comb
    begin
        q_next = q_in;
        if (q_in.req.cmd == CMD_LOAD)
        begin
            if (!own_slot && valid_reg && nonempty_reg &&
                (q_in.req.region_length != '0) &&
                (q_end > SPAN_W'(start_reg)) && (end_reg > SPAN_W'(q_start)))
            begin
                q_next.overlap = 1'b1;
            end
        end
        else if (!q_in.hit && valid_reg &&
                 (SPAN_W'(q_addr) >= SPAN_W'(start_reg)) &&
                 (SPAN_W'(q_addr) < end_reg))
        begin
            q_next.hit       = 1'b1;
            q_next.hit_owner = owner_reg;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
            if (wr_hit)
            begin
                valid_reg <= wr.set;
            end
        end
    end

    // entry and query payload
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        if (wr_hit && wr.set)
        begin
            start_reg    <= w_start;
            end_reg      <= SPAN_W'(w_start) + SPAN_W'(wr.length);
            owner_reg    <= wr.owner;
            nonempty_reg <= (wr.length != '0);
        end
    end

    assign vld_out = vld_reg;
    assign q_out   = q_reg;

endmodule

`default_nettype wire

>>> rtl/core/address_region_message_router_unit.sv
// ----------------------------------------------------------------------------
// address_region_message_router_unit
// Routes messages by source id, destination id or address region and loads
// the region table, one transaction at a time through a row of region cells.
// ----------------------------------------------------------------------------
//  channel   signals                       direction  handshake
//  request   start, busy, req              in         start & !busy
//  response  done, rsp                     out        done, one cycle
//  config    cfg_valid, cfg_ready, cfg_data in        cfg_valid & cfg_ready
//
//  a request walks the cell row one cell per cycle; done is registered from
//  the valid of the last cell and busy falls at the edge at which done rises,
//  so a new request can be taken while done is high
//  reset clears all region valid bits at once and sets the device count to 16
//  the response side cannot stall; the config port is always ready
// ----------------------------------------------------------------------------
`default_nettype none

module address_region_message_router_unit #(
    parameter int REGIONS   = armr_pkg::REGIONS_DEF,
    parameter int DEVICES   = armr_pkg::DEVICES_DEF,
    parameter int ADDR_BITS = armr_pkg::ADDR_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire armr_pkg::req_t               req,
    output logic                              done,
    output armr_pkg::rsp_t                    rsp,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [armr_pkg::CNT_W-1:0]   cfg_data
);
    import armr_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    logic [CNT_W-1:0] dev_count_reg;
    logic             accept;
    query_t           q_head;
    query_t           q_chain [REGIONS];
    logic [REGIONS-1:0] vld_chain;
    query_t           q_tail;
    logic             tail_vld;
    tbl_wr_t          wr;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             done_reg;

    // id below both the live device count and DEVICES
    function automatic logic id_ok(input logic [ID_W-1:0] id,
                                   input logic [CNT_W-1:0] cnt);
        logic r;
        r = (32'(id) < 32'(cnt)) && (32'(id) < 32'(DEVICES));
        return r;
    endfunction

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // device count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_count_reg <= CNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            dev_count_reg <= cfg_data;
        end
    end

    // query entering the first cell
    always_comb
    begin
        q_head           = '0;
        q_head.req       = req;
    end

    // row of region cells
    for (genvar i = 0; i < REGIONS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            armr_cell #(.ADDR_BITS(ADDR_BITS), .INDEX(i)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .vld_in  (accept),
                .q_in    (q_head),
                .wr      (wr),
                .vld_out (vld_chain[i]),
                .q_out   (q_chain[i])
            );
        end
        else
        begin : g_next
            armr_cell #(.ADDR_BITS(ADDR_BITS), .INDEX(i)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .vld_in  (vld_chain[i-1]),
                .q_in    (q_chain[i-1]),
                .wr      (wr),
                .vld_out (vld_chain[i]),
                .q_out   (q_chain[i])
            );
        end
    end

    assign q_tail   = q_chain[REGIONS-1];
    assign tail_vld = vld_chain[REGIONS-1];

    // final decision and table write
    always_comb
    begin
        wr        = '0;
        wr.slot   = q_tail.req.slot_index;
        wr.start  = q_tail.req.region_start;
        wr.length = q_tail.req.region_length;
        wr.owner  = q_tail.req.region_device;
        wr.set    = q_tail.req.region_enabled;
        rsp_next  = '0;
        if (q_tail.req.cmd == CMD_LOAD)
        begin
            rsp_next.route_kind = KIND_LOAD;
            if (32'(q_tail.req.slot_index) >= 32'(REGIONS))
            begin
                rsp_next.status = STAT_BAD_ID;
            end
            else if (!q_tail.req.region_enabled)
            begin
                rsp_next.status = STAT_OK;
                wr.en           = tail_vld;
            end
            else if (!id_ok(q_tail.req.region_device, dev_count_reg))
            begin
                rsp_next.status = STAT_BAD_ID;
            end
            else if (q_tail.overlap)
            begin
                rsp_next.status = STAT_OVERLAP;
            end
            else
            begin
                rsp_next.status = STAT_OK;
                wr.en           = tail_vld;
            end
        end
        else if (q_tail.req.msg_is_read_response == READ_RSP_MARK)
        begin
            rsp_next.route_kind = KIND_BY_SRC;
            if (id_ok(q_tail.req.msg_src_id, dev_count_reg))
            begin
                rsp_next.dest_device = q_tail.req.msg_src_id;
                rsp_next.status      = STAT_OK;
            end
            else
            begin
                rsp_next.status = STAT_BAD_ID;
            end
        end
        else if (q_tail.req.msg_has_dst)
        begin
            rsp_next.route_kind = KIND_BY_DST;
            if (id_ok(q_tail.req.msg_dst_id, dev_count_reg))
            begin
                rsp_next.dest_device = q_tail.req.msg_dst_id;
                rsp_next.status      = STAT_OK;
            end
            else
            begin
                rsp_next.status = STAT_BAD_ID;
            end
        end
        else
        begin
            rsp_next.route_kind = KIND_BY_ADDR;
            if (!q_tail.hit)
            begin
                rsp_next.status = STAT_MISS;
            end
            else if (id_ok(q_tail.hit_owner, dev_count_reg))
            begin
                rsp_next.dest_device = q_tail.hit_owner;
                rsp_next.status      = STAT_OK;
            end
            else
            begin
                rsp_next.status = STAT_BAD_ID;
            end
        end
    end

    // controller next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (accept)
                begin
                    state_next = CTL_SWEEP;
                end
            end
            CTL_SWEEP:
            begin
                if (tail_vld)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    // controller outputs
    always_comb
    begin
        unique case (state_reg)
            CTL_IDLE:  busy = 1'b0;
            CTL_SWEEP: busy = 1'b1;
            default:   busy = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= tail_vld;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (tail_vld)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    // at most one transaction in the cell row
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(vld_chain))
        else $error("more than one transaction in the cell row");

    // an accepted transaction keeps the unit busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after acceptance");

    // a result only follows a sweep
    a_done_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding sweep");

    // failed results carry device zero
    a_fail_dev_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((rsp.status == STAT_OK) || (rsp.dest_device == '0)))
        else $error("nonzero device on a failed result");
`endif

endmodule

`default_nettype wire
